// ===== rtl/ttm_pkg.sv =====
// Package of the tick timer: payload types, operation codes, register indexes and mode codes.
`default_nettype none

package ttm_pkg;

	localparam int unsigned DATA_WIDTH = 32;

	// Operation carried by one request beat.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} ttm_op_t;

	// Register map.
	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_RELOAD  = 3'd1;
	localparam logic [2:0] REG_CURRENT = 3'd2;
	localparam logic [2:0] REG_MODE    = 3'd3;
	localparam logic [2:0] REG_PERIODS = 3'd4;
	localparam logic [2:0] REG_ELAPSED = 3'd5;

	// Control register bit positions.
	localparam int unsigned CTRL_RUN_BIT  = 0;
	localparam int unsigned CTRL_IRQ_BIT  = 1;
	localparam int unsigned CTRL_CLK_BIT  = 2;
	localparam int unsigned CTRL_FLAG_BIT = 16;

	// Expiry handling modes.
	localparam logic [1:0] MODE_REPEAT   = 2'd0;
	localparam logic [1:0] MODE_PLAIN    = 2'd1;
	localparam logic [1:0] MODE_SINGLE   = 2'd2;
	localparam logic [1:0] MODE_PERIODIC = 2'd3;

	typedef struct packed {
		logic [1:0]            op;
		logic                  ref_pulse;
		logic [2:0]            reg_index;
		logic [DATA_WIDTH-1:0] write_data;
	} ttm_req_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] read_data;
		logic                  irq;
		logic                  done_res;
	} ttm_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ttm_if.sv =====
// Valid/ready channel interfaces for the request and response streams of the tick timer.
`default_nettype none

interface ttm_req_if;
	import ttm_pkg::*;

	logic     valid;
	logic     ready;
	ttm_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ttm_rsp_if;
	import ttm_pkg::*;

	logic     valid;
	logic     ready;
	ttm_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tick_timer_with_modes_top.sv =====
// Top level of the down-counting tick timer with expiry handling modes.
`default_nettype none

// Channel | Direction | Payload                                   | Handshake
// req     | in        | op, ref_pulse, reg_index, write_data      | valid / ready
// rsp     | out       | read_data, irq, done_res                  | valid / ready
//
// Every request beat is processed in the cycle it is accepted: the timer state
// registers update at that edge and the response lands in the output register.
// One beat per cycle is sustained while rsp does not stall; the response shows in the cycle after its beat.
// The request side stays ready while the output register is empty or is being
// drained in the same cycle, so req is held back for as long as rsp stalls.
// The asynchronous reset clears all timer state and empties the output register.

module tick_timer_with_modes_top #(
	parameter int unsigned COUNTER_WIDTH      = 24,
	parameter int unsigned PERIOD_COUNT_WIDTH = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	ttm_req_if.sink    req,
	ttm_rsp_if.source  rsp
);
	import ttm_pkg::*;

	// Timer state. The counter and reload registers are COUNTER_WIDTH wide and
	// the period count is PERIOD_COUNT_WIDTH wide; reads zero-extend them.
	logic                          run_en_q;
	logic                          irq_en_q;
	logic                          clk_sel_q;
	logic                          zero_flag_q;
	logic [COUNTER_WIDTH-1:0]      reload_q;
	logic [COUNTER_WIDTH-1:0]      current_q;
	logic [1:0]                    mode_q;
	logic [PERIOD_COUNT_WIDTH-1:0] periods_q;

	// Next-state values, valid when a beat is accepted.
	logic                          run_en_d;
	logic                          irq_en_d;
	logic                          clk_sel_d;
	logic                          zero_flag_d;
	logic [COUNTER_WIDTH-1:0]      reload_d;
	logic [COUNTER_WIDTH-1:0]      current_d;
	logic [1:0]                    mode_d;
	logic [PERIOD_COUNT_WIDTH-1:0] periods_d;

	ttm_rsp_t rsp_d;
	ttm_rsp_t rsp_s1;
	logic     rsp_valid_s1;

	logic     req_fire;
	logic     count_active;
	logic     expire;
	logic [COUNTER_WIDTH-1:0] elapsed;

	// The output register may take a new beat when it is empty or is being read.
	assign req.ready = !rsp_valid_s1 || rsp.ready;
	assign req_fire  = req.valid && req.ready;

	assign count_active = run_en_q && (clk_sel_q || req.data.ref_pulse);
	// A decrement lands on zero when the counter currently holds one.
	assign expire  = count_active && (current_q == COUNTER_WIDTH'(1));
	assign elapsed = reload_q - current_q;

	always_comb begin
		run_en_d    = run_en_q;
		irq_en_d    = irq_en_q;
		clk_sel_d   = clk_sel_q;
		zero_flag_d = zero_flag_q;
		reload_d    = reload_q;
		current_d   = current_q;
		mode_d      = mode_q;
		periods_d   = periods_q;
		rsp_d       = '0;

		unique case (req.data.op)
			OP_TICK: begin
				if (count_active) begin
					if (current_q == '0) begin
						current_d = reload_q;
					end else begin
						current_d = current_q - COUNTER_WIDTH'(1);
					end
				end
				if (expire) begin
					zero_flag_d = 1'b1;
					if (irq_en_q) begin
						rsp_d.irq = 1'b1;
						// Repeat-count runs stop once the last period has gone;
						// single-shot runs stop at the first expiry.
						if (mode_q == MODE_REPEAT) begin
							if (periods_q <= PERIOD_COUNT_WIDTH'(1)) begin
								periods_d      = '0;
								reload_d       = '0;
								run_en_d       = 1'b0;
								irq_en_d       = 1'b0;
								rsp_d.done_res = 1'b1;
							end else begin
								periods_d = periods_q - PERIOD_COUNT_WIDTH'(1);
							end
						end else if (mode_q == MODE_SINGLE) begin
							reload_d       = '0;
							run_en_d       = 1'b0;
							irq_en_d       = 1'b0;
							rsp_d.done_res = 1'b1;
						end
					end
				end
			end
			OP_WRITE: begin
				unique case (req.data.reg_index)
					REG_CTRL: begin
						run_en_d  = req.data.write_data[CTRL_RUN_BIT];
						irq_en_d  = req.data.write_data[CTRL_IRQ_BIT];
						clk_sel_d = req.data.write_data[CTRL_CLK_BIT];
					end
					REG_RELOAD:  reload_d = req.data.write_data[COUNTER_WIDTH-1:0];
					REG_CURRENT: begin
						// Any value written clears the counter and the count flag.
						current_d   = '0;
						zero_flag_d = 1'b0;
					end
					REG_MODE:    mode_d = req.data.write_data[1:0];
					REG_PERIODS: periods_d = req.data.write_data[PERIOD_COUNT_WIDTH-1:0];
					default: ;
				endcase
			end
			OP_READ: begin
				unique case (req.data.reg_index)
					REG_CTRL: begin
						rsp_d.read_data[CTRL_RUN_BIT]  = run_en_q;
						rsp_d.read_data[CTRL_IRQ_BIT]  = irq_en_q;
						rsp_d.read_data[CTRL_CLK_BIT]  = clk_sel_q;
						rsp_d.read_data[CTRL_FLAG_BIT] = zero_flag_q;
						// Reading control consumes the count flag.
						zero_flag_d = 1'b0;
					end
					REG_RELOAD:  rsp_d.read_data = DATA_WIDTH'(reload_q);
					REG_CURRENT: rsp_d.read_data = DATA_WIDTH'(current_q);
					REG_MODE:    rsp_d.read_data = DATA_WIDTH'(mode_q);
					REG_PERIODS: rsp_d.read_data = DATA_WIDTH'(periods_q);
					REG_ELAPSED: rsp_d.read_data = DATA_WIDTH'(elapsed);
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_en_q    <= 1'b0;
			irq_en_q    <= 1'b0;
			clk_sel_q   <= 1'b0;
			zero_flag_q <= 1'b0;
			reload_q    <= '0;
			current_q   <= '0;
			mode_q      <= MODE_REPEAT;
			periods_q   <= '0;
		end else if (req_fire) begin
			run_en_q    <= run_en_d;
			irq_en_q    <= irq_en_d;
			clk_sel_q   <= clk_sel_d;
			zero_flag_q <= zero_flag_d;
			reload_q    <= reload_d;
			current_q   <= current_d;
			mode_q      <= mode_d;
			periods_q   <= periods_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_s1 <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_s1;
	assign rsp.data  = rsp_s1;

`ifndef SYNTHESIS
	// A finished run is always reported together with an interrupt.
	a_done_has_irq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s1 && rsp_s1.done_res |-> rsp_s1.irq)
		else $error("done_res without irq");

	// After a finished run the timer is stopped with no reload left.
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && rsp_d.done_res |=> !run_en_q && !irq_en_q && (reload_q == '0))
		else $error("timer still armed after finished run");

	// An interrupt is raised only when the counter lands on zero.
	a_irq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && rsp_d.irq |=> (current_q == '0) && zero_flag_q)
		else $error("irq without counter at zero");

	// A write to the current register clears counter and flag.
	a_cur_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.data.op == OP_WRITE) && (req.data.reg_index == REG_CURRENT)
		|=> (current_q == '0) && !zero_flag_q)
		else $error("current write did not clear the counter");
`endif

endmodule

`default_nettype wire
